>>> rtl/h4df_pkg.sv
package h4df_pkg;

   // deframer phases
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HDR     = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_DISCARD = 2'd3;

   // packet type bytes on the wire
   localparam logic [7:0] TYPE_CMD = 8'h01;
   localparam logic [7:0] TYPE_ACL = 8'h02;
   localparam logic [7:0] TYPE_ISO = 8'h05;

   // packet kinds
   localparam logic [1:0] KIND_CMD = 2'd0;
   localparam logic [1:0] KIND_ACL = 2'd1;
   localparam logic [1:0] KIND_ISO = 2'd2;

   // byte classification
   localparam logic [2:0] BK_DROP    = 3'd0;
   localparam logic [2:0] BK_TYPE    = 3'd1;
   localparam logic [2:0] BK_HEADER  = 3'd2;
   localparam logic [2:0] BK_PAYLOAD = 3'd3;
   localparam logic [2:0] BK_DISCARD = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN = 2'd1;
   localparam logic [1:0] ERR_NO_BUF  = 2'd2;
   localparam logic [1:0] ERR_TOO_LONG = 2'd3;

   // header sizes
   localparam logic [15:0] HDR_SIZE_CMD   = 16'd3;
   localparam logic [15:0] HDR_SIZE_OTHER = 16'd4;

   // configuration register map
   localparam logic [31:0] MAX_LEN_RESET = 32'd255;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_available;
   } req_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [2:0]  byte_kind;
      logic [1:0]  packet_kind;
      logic [15:0] payload_length;
      logic        packet_end;
      logic [1:0]  error_code;
   } rsp_type;

   // payload length from the length bytes of the header (one for commands, two otherwise)
   function automatic logic [15:0] hdr_length(input logic [1:0] kind,
                                              input logic [7:0] lo,
                                              input logic [7:0] hi);
      logic [15:0] full;
      full = {hi, lo};
      case (kind)
         KIND_CMD: hdr_length = {8'd0, lo};
         KIND_ACL: hdr_length = full;
         default:  hdr_length = {2'b00, full[13:0]};
      endcase
   endfunction

endpackage

>>> rtl/hci_h4_uart_deframer_core.sv
// H4 UART receive deframer.
// req channel: one received UART byte per transaction with the flag that a
// packet buffer is free (looked at only on the last header byte).
// rsp channel: one result per byte: the byte, its class (dropped type, type,
// header, payload, discarded), the packet kind, the payload length from the
// header, an end-of-packet mark and an error code.
// APB port: register 0 at address 0 is the payload room in bytes (reset 255);
// write it only while no byte is in flight.
// The result of a byte is registered and shows on rsp in the cycle after its acceptance.
// Throughput: one byte per cycle while results are taken; the whole classification is one pass of
// compare and count logic ahead of the output register.
// Reset puts the deframer in idle waiting for a type byte and empties the
// output register. When the receiver stalls, the result is held and req_ready
// drops until it is taken; ready stays high while the result moves on.
module hci_h4_uart_deframer_core
   import h4df_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0] max_len_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     result;
   logic        accept;

   // take a byte whenever the output register is free or being emptied
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   h4df_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .item    (req_payload),
      .max_len (max_len_ff),
      .result  (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET[15:0];
      end else if (psel && penable && pwrite && !paddr[2]) begin
         max_len_ff <= pwdata[15:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {16'd0, max_len_ff};

   // a stalled result blocks new input
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   // a dropped type byte carries the unknown-type error and nothing else does
   a_drop_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.byte_kind == BK_DROP) |->
         (rsp_payload.error_code == ERR_UNKNOWN) && !rsp_payload.packet_end)
      else $error("dropped byte without unknown-type error");

   // the end mark never comes with an error
   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.packet_end |->
         (rsp_payload.error_code == ERR_NONE) &&
         (rsp_payload.byte_kind == BK_HEADER || rsp_payload.byte_kind == BK_PAYLOAD))
      else $error("packet end on a bad byte");

   // a result appears in the cycle after an accepted byte
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted byte produced no result");

endmodule

>>> rtl/h4df_parser.sv
module h4df_parser
   import h4df_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     item,
   input  logic [15:0] max_len,
   output rsp_type     result
);

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  lo_ff, lo_in;
   logic [7:0]  hi_ff, hi_in;

   logic [7:0]  b;
   logic [1:0]  idx;
   logic [1:0]  size_lo;
   logic        last;
   logic [7:0]  lo_cur;
   logic [7:0]  hi_cur;
   logic [15:0] len_cur;

   assign b = item.rx_byte;

   // header slot of this byte and the length as seen with this byte stored
   assign size_lo = (kind_ff == KIND_CMD) ? HDR_SIZE_CMD[1:0] : HDR_SIZE_OTHER[1:0];
   assign idx     = size_lo - left_ff[1:0];
   assign last    = (left_ff <= 16'd1);
   assign lo_cur  = (phase_ff == PH_HDR && idx == 2'd2) ? b : lo_ff;
   assign hi_cur  = (phase_ff == PH_HDR && idx == 2'd3) ? b : hi_ff;
   assign len_cur = hdr_length(kind_ff, lo_cur, hi_cur);

   // classify the byte and work out the next state
   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      left_in  = left_ff;
      lo_in    = lo_cur;
      hi_in    = hi_cur;
      result.data_byte      = b;
      result.byte_kind      = BK_DROP;
      result.packet_kind    = kind_ff;
      result.payload_length = 16'd0;
      result.packet_end     = 1'b0;
      result.error_code     = ERR_NONE;
      case (phase_ff)
         PH_IDLE: begin
            result.packet_kind = KIND_CMD;
            if (b == TYPE_CMD || b == TYPE_ACL || b == TYPE_ISO) begin
               if (b == TYPE_CMD) begin
                  kind_in = KIND_CMD;
                  left_in = HDR_SIZE_CMD;
               end else if (b == TYPE_ACL) begin
                  kind_in = KIND_ACL;
                  left_in = HDR_SIZE_OTHER;
               end else begin
                  kind_in = KIND_ISO;
                  left_in = HDR_SIZE_OTHER;
               end
               phase_in           = PH_HDR;
               result.byte_kind   = BK_TYPE;
               result.packet_kind = kind_in;
            end else begin
               result.error_code = ERR_UNKNOWN;
            end
         end
         PH_HDR: begin
            result.byte_kind = BK_HEADER;
            if (last) begin
               left_in               = 16'd0;
               result.payload_length = len_cur;
               if (!item.buffer_available) begin
                  result.error_code = ERR_NO_BUF;
                  phase_in          = PH_IDLE;
               end else if (len_cur > max_len) begin
                  result.error_code = ERR_TOO_LONG;
                  left_in           = len_cur;
                  phase_in          = PH_DISCARD;
               end else if (len_cur == 16'd0) begin
                  result.packet_end = 1'b1;
                  phase_in          = PH_IDLE;
               end else begin
                  left_in  = len_cur;
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               left_in = left_ff - 16'd1;
            end
         end
         PH_PAYLOAD: begin
            result.byte_kind      = BK_PAYLOAD;
            result.payload_length = len_cur;
            if (last) begin
               left_in           = 16'd0;
               result.packet_end = 1'b1;
               phase_in          = PH_IDLE;
            end else begin
               left_in = left_ff - 16'd1;
            end
         end
         default: begin
            result.byte_kind      = BK_DISCARD;
            result.payload_length = len_cur;
            if (last) begin
               left_in  = 16'd0;
               phase_in = PH_IDLE;
            end else begin
               left_in = left_ff - 16'd1;
            end
         end
      endcase
   end

   // advance state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff  <= KIND_CMD;
         left_ff  <= 16'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         left_ff  <= left_in;
      end
   end

   // hold the length bytes of the header
   always_ff @(posedge clock) begin
      if (accept) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

endmodule

>>> sim/h4_byte_checker.sv
module h4_byte_checker
   import h4df_pkg::*;
#(
   parameter logic [2:0] ROOM_ADDR = 3'd0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          fail_count,
   output int          outstanding,
   output int          bytes_taken,
   output int          handshakes
);

   // deframer state as predicted from the byte stream
   logic [1:0]  st_phase;
   logic [1:0]  st_kind;
   logic [15:0] st_left;
   logic [15:0] room;
   logic [7:0]  hdr_bytes [4];
   rsp_type     pending_results [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
      bytes_taken = 0;
      handshakes  = 0;
   end

   // length field of the collected header
   function automatic logic [15:0] header_len();
      logic [7:0] lo;
      logic [7:0] hi;
      lo = hdr_bytes[2];
      hi = hdr_bytes[3];
      if (st_kind == KIND_CMD)
         return {8'h00, lo};
      else if (st_kind == KIND_ACL)
         return {hi, lo};
      return {2'b00, hi[5:0], lo};
   endfunction

   // classify one byte and advance the predicted state
   function automatic rsp_type deframe_byte(input req_type item);
      rsp_type     res;
      logic [15:0] hdr_size;
      logic [1:0]  slot;
      logic [15:0] len;
      res = '0;
      res.data_byte = item.rx_byte;
      case (st_phase)
         PH_IDLE: begin
            if (item.rx_byte == TYPE_CMD || item.rx_byte == TYPE_ACL ||
                item.rx_byte == TYPE_ISO) begin
               if (item.rx_byte == TYPE_CMD)
                  st_kind = KIND_CMD;
               else if (item.rx_byte == TYPE_ACL)
                  st_kind = KIND_ACL;
               else
                  st_kind = KIND_ISO;
               st_left = (st_kind == KIND_CMD) ? HDR_SIZE_CMD : HDR_SIZE_OTHER;
               st_phase = PH_HDR;
               res.byte_kind = BK_TYPE;
               res.packet_kind = st_kind;
            end else begin
               res.byte_kind = BK_DROP;
               res.error_code = ERR_UNKNOWN;
            end
         end
         PH_HDR: begin
            hdr_size = (st_kind == KIND_CMD) ? HDR_SIZE_CMD : HDR_SIZE_OTHER;
            slot = 2'(hdr_size - st_left);
            hdr_bytes[slot] = item.rx_byte;
            res.byte_kind = BK_HEADER;
            res.packet_kind = st_kind;
            if (st_left <= 16'd1) begin
               st_left = '0;
               len = header_len();
               res.payload_length = len;
               if (!item.buffer_available) begin
                  res.error_code = ERR_NO_BUF;
                  st_phase = PH_IDLE;
               end else if (len > room) begin
                  res.error_code = ERR_TOO_LONG;
                  st_left = len;
                  st_phase = PH_DISCARD;
               end else if (len == '0) begin
                  res.packet_end = 1'b1;
                  st_phase = PH_IDLE;
               end else begin
                  st_left = len;
                  st_phase = PH_PAYLOAD;
               end
            end else begin
               st_left--;
            end
         end
         default: begin
            // payload and discard count down alike; only payload marks its end
            res.byte_kind = (st_phase == PH_PAYLOAD) ? BK_PAYLOAD : BK_DISCARD;
            res.packet_kind = st_kind;
            res.payload_length = header_len();
            if (st_left <= 16'd1) begin
               st_left = '0;
               res.packet_end = (st_phase == PH_PAYLOAD);
               st_phase = PH_IDLE;
            end else begin
               st_left--;
            end
         end
      endcase
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         st_phase = PH_IDLE;
         st_kind = KIND_CMD;
         st_left = '0;
         room = MAX_LEN_RESET[15:0];
         for (int i = 0; i < 4; i++)
            hdr_bytes[i] = '0;
         pending_results.delete();
         outstanding = 0;
      end else begin
         // track register writes, check register reads
         if (psel && penable && pready && paddr == ROOM_ADDR) begin
            if (pwrite)
               room = pwdata[15:0];
            else
               check_field("prdata", {16'd0, room}, prdata);
         end
         // retire the oldest expected result
         if (rsp_valid && rsp_ready) begin
            handshakes++;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, got %p",
                        $time, rsp_payload);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("data_byte", want.data_byte, rsp_payload.data_byte);
               check_field("byte_kind", want.byte_kind, rsp_payload.byte_kind);
               check_field("packet_kind", want.packet_kind, rsp_payload.packet_kind);
               check_field("payload_length", want.payload_length,
                           rsp_payload.payload_length);
               check_field("packet_end", want.packet_end, rsp_payload.packet_end);
               check_field("error_code", want.error_code, rsp_payload.error_code);
            end
         end
         // predict the result of each accepted byte
         if (req_valid && req_ready) begin
            handshakes++;
            bytes_taken++;
            pending_results.push_back(deframe_byte(req_payload));
         end
         outstanding = pending_results.size();
      end
   end

endmodule

>>> sim/hci_h4_uart_deframer_core_test.sv
module hci_h4_uart_deframer_core_test;
   import h4df_pkg::*;

   localparam logic [2:0] ROOM_ADDR = 3'd0;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES = 80;

   typedef enum {SINK_FREE, SINK_COIN, SINK_SLOW, SINK_TOGGLE} sink_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int fail_count;
   int outstanding;
   int bytes_taken;
   int handshakes;
   int issued = 0;
   int burst_left = 8;
   int seen_hs = 0;
   int quiet = 0;
   sink_mode_type sink_mode = SINK_FREE;
   int sink_left = 0;

   hci_h4_uart_deframer_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   h4_byte_checker #(.ROOM_ADDR(ROOM_ADDR)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .bytes_taken (bytes_taken),
      .handshakes  (handshakes)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stall the result side in windows of changing behavior
   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         sink_left = $urandom_range(8, 80);
      end
      sink_left--;
      case (sink_mode)
         SINK_FREE:   rsp_ready = 1'b1;
         SINK_COIN:   rsp_ready = 1'($urandom);
         SINK_SLOW:   rsp_ready = ($urandom_range(0, 3) == 0);
         default:     rsp_ready = ~rsp_ready;
      endcase
   end

   // abort when no transaction moves for too long
   always @(negedge clock) begin
      if (handshakes != seen_hs) begin
         seen_hs = handshakes;
         quiet = 0;
      end else begin
         quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("hci_h4_uart_deframer_core verification failed");
         $finish;
      end
   end

   // hold one byte on the request channel until it is taken, then maybe pause
   task automatic send_byte(input logic [7:0] b, input logic buf_free);
      int gap;
      req_payload.rx_byte = b;
      req_payload.buffer_available = buf_free;
      req_valid = 1'b1;
      issued++;
      do @(negedge clock); while (bytes_taken != issued);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 24);
      end
   endtask

   task automatic reg_access(input logic wr, input logic [31:0] data);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = wr;
      paddr = ROOM_ADDR;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // wait until every byte has its result back
   task automatic drain();
      req_valid = 1'b0;
      while (bytes_taken != issued || outstanding != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // well-formed packet with random header content and length
   task automatic send_packet();
      logic [1:0]  kind;
      logic [15:0] len;
      logic        last_buf;
      int          pick;
      kind = 2'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      if (pick < 70)
         len = 16'($urandom_range(0, 12));
      else if (pick < 90)
         len = 16'($urandom_range(13, 40));
      else
         len = 16'($urandom_range(200, 320));
      last_buf = ($urandom_range(0, 9) != 0);
      case (kind)
         KIND_CMD: begin
            if (len > 16'd255)
               len = 16'd255;
            send_byte(TYPE_CMD, 1'($urandom));
            send_byte(8'($urandom), 1'($urandom));
            send_byte(8'($urandom), 1'($urandom));
            send_byte(len[7:0], last_buf);
         end
         KIND_ACL: begin
            send_byte(TYPE_ACL, 1'($urandom));
            send_byte(8'($urandom), 1'($urandom));
            send_byte(8'($urandom), 1'($urandom));
            send_byte(len[7:0], 1'($urandom));
            send_byte(len[15:8], last_buf);
         end
         default: begin
            // top two length bits are flags and must be masked off
            send_byte(TYPE_ISO, 1'($urandom));
            send_byte(8'($urandom), 1'($urandom));
            send_byte(8'($urandom), 1'($urandom));
            send_byte(len[7:0], 1'($urandom));
            send_byte({2'($urandom), len[13:8]}, last_buf);
         end
      endcase
      if (last_buf)
         repeat (len) send_byte(8'($urandom), 1'($urandom));
   endtask

   // bytes that are not packet types
   task automatic send_noise();
      logic [7:0] b;
      repeat ($urandom_range(1, 3)) begin
         b = 8'($urandom);
         if (b == TYPE_CMD || b == TYPE_ACL || b == TYPE_ISO)
            b[7] = 1'b1;
         send_byte(b, 1'($urandom));
      end
   endtask

   task automatic run_phase(input logic [15:0] new_room, input int budget);
      int start;
      drain();
      reg_access(1'b1, {16'd0, new_room});
      reg_access(1'b0, '0);
      start = issued;
      while (issued - start < budget) begin
         if ($urandom_range(0, 9) == 0)
            send_noise();
         else
            send_packet();
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
      reg_access(1'b0, '0);

      // unknown type bytes
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      // command with empty payload
      send_byte(TYPE_CMD, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h0C, 1'b1);
      send_byte(8'h00, 1'b1);
      // ACL without a free buffer
      send_byte(TYPE_ACL, 1'b1);
      send_byte(8'h01, 1'b1);
      send_byte(8'h20, 1'b0);
      send_byte(8'h05, 1'b1);
      send_byte(8'h00, 1'b0);
      // ISO with flag bits set in the length
      send_byte(TYPE_ISO, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'hC0, 1'b1);
      send_byte(8'hA5, 1'b0);

      // payload longer than the room
      drain();
      reg_access(1'b1, 32'd1);
      reg_access(1'b0, '0);
      send_byte(TYPE_ACL, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h0F, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h5A, 1'b1);
      send_byte(8'hFF, 1'b0);

      run_phase(16'd0, PHASE_BYTES);
      run_phase(16'hFFFF, PHASE_BYTES);
      run_phase(16'd20, PHASE_BYTES);
      run_phase(16'($urandom_range(1, 400)), PHASE_BYTES);
      run_phase(16'd255, PHASE_BYTES);

      drain();
      repeat (4) @(negedge clock);
      if (fail_count == 0)
         $display("hci_h4_uart_deframer_core verification clean");
      else
         $display("hci_h4_uart_deframer_core verification failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/h4df_pkg.sv
rtl/h4df_parser.sv
rtl/hci_h4_uart_deframer_core.sv
sim/h4_byte_checker.sv
sim/hci_h4_uart_deframer_core_test.sv
